@@ src/tpvc_pkg.sv @@
// Shared codes, the load broadcast bundle and the mismatch counter
// for the ternary pattern vote classifier. No dependencies.
package tpvc_pkg;

	// Input command codes
	localparam logic [1:0] CMD_CLEAR    = 2'd0;
	localparam logic [1:0] CMD_LOAD     = 2'd1;
	localparam logic [1:0] CMD_CLASSIFY = 2'd2;

	// Verdict codes
	localparam logic [1:0] VERDICT_FIRST  = 2'd0;
	localparam logic [1:0] VERDICT_SECOND = 2'd1;
	localparam logic [1:0] VERDICT_TIE    = 2'd2;

	// Port widths fixed by the item layout
	localparam int FEAT_W      = 64;
	localparam int WEIGHT_IN_W = 16;
	localparam int SCORE_W     = 22;
	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	// Saturating mismatch codes
	localparam logic [1:0] MISS_NONE = 2'd0;
	localparam logic [1:0] MISS_MANY = 2'd3;

	// Pattern write broadcast to every cell
	typedef struct packed {
		logic                   en;
		logic                   cls;
		logic [5:0]             slot;
		logic [FEAT_W-1:0]      care;
		logic [FEAT_W-1:0]      vals;
		logic [WEIGHT_IN_W-1:0] weight;
	} load_t;

	// Count set bits, saturating at three, through a six-level tree
	function automatic logic [1:0] miss_sat(input logic [FEAT_W-1:0] m);
		logic [1:0] c [FEAT_W];
		logic [2:0] t;
		int         lv;
		int         k;
		for (k = 0; k < FEAT_W; k++) begin
			c[k] = {1'b0, m[k]};
		end
		for (lv = 1; lv < FEAT_W; lv = lv * 2) begin
			for (k = 0; k < FEAT_W; k = k + 2 * lv) begin
				t    = {1'b0, c[k]} + {1'b0, c[k+lv]};
				c[k] = (t > 3'd3) ? MISS_MANY : t[1:0];
			end
		end
		return c[0];
	endfunction

endpackage

@@ src/tpvc_cell.sv @@
// One cell of the pattern chain: holds the slot of both class tables,
// scores the passing object and hands it on. Depends on tpvc_pkg.
module tpvc_cell #(
	parameter int IDX         = 0,
	parameter int WEIGHT_BITS = 16,
	parameter int SUM_W       = 23
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tpvc_pkg::load_t              ld,
	input  logic                         clr,
	input  logic                         mode,
	input  logic                         tok_in,
	input  logic [tpvc_pkg::FEAT_W-1:0]  obj_in,
	input  logic [SUM_W-1:0]             s0_in,
	input  logic [SUM_W-1:0]             s1_in,
	output logic                         tok_out,
	output logic [tpvc_pkg::FEAT_W-1:0]  obj_out,
	output logic [SUM_W-1:0]             s0_out,
	output logic [SUM_W-1:0]             s1_out
);

	logic [tpvc_pkg::FEAT_W-1:0] care_q   [2];
	logic [tpvc_pkg::FEAT_W-1:0] vals_q   [2];
	logic [WEIGHT_BITS-1:0]      weight_q [2];
	logic [1:0]                  valid_q;
	logic                        hit;
	logic [1:0]                  miss0;
	logic [1:0]                  miss1;
	logic                        vote0;
	logic                        vote1;
	logic                        tok_q;
	logic [tpvc_pkg::FEAT_W-1:0] obj_q;
	logic [SUM_W-1:0]            s0_q;
	logic [SUM_W-1:0]            s1_q;

	assign hit = ld.en && ({2'b00, ld.slot} == 8'(IDX));

	// Store a pattern addressed to this slot
	always_ff @(posedge clk) begin
		if (hit) begin
			care_q[ld.cls]   <= ld.care;
			vals_q[ld.cls]   <= ld.vals;
			weight_q[ld.cls] <= WEIGHT_BITS'(ld.weight);
		end
	end

	// Track valid bits: clear drops both, load sets one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 2'b00;
		end else if (clr) begin
			valid_q <= 2'b00;
		end else if (hit) begin
			valid_q[ld.cls] <= 1'b1;
		end
	end

	// Score the passing object against both patterns
	always_comb begin
		miss0 = tpvc_pkg::miss_sat(care_q[0] & (vals_q[0] ^ obj_in));
		miss1 = tpvc_pkg::miss_sat(care_q[1] & (vals_q[1] ^ obj_in));
		vote0 = valid_q[0] && (mode ? (miss0 != tpvc_pkg::MISS_MANY)
		                            : (miss0 == tpvc_pkg::MISS_NONE));
		vote1 = valid_q[1] && (mode ? (miss1 != tpvc_pkg::MISS_MANY)
		                            : (miss1 == tpvc_pkg::MISS_NONE));
	end

	// Advance the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// Advance object and partial sums
	always_ff @(posedge clk) begin
		obj_q <= obj_in;
		s0_q  <= s0_in + (vote0 ? SUM_W'(weight_q[0]) : '0);
		s1_q  <= s1_in + (vote1 ? SUM_W'(weight_q[1]) : '0);
	end

	assign tok_out = tok_q;
	assign obj_out = obj_q;
	assign s0_out  = s0_q;
	assign s1_out  = s1_q;

endmodule

@@ src/ternary_pattern_vote_classifier_top.sv @@
// Top level of the ternary pattern vote classifier: command decode, the
// row of pattern cells and the result register. Depends on tpvc_pkg, tpvc_cell.
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    cmd, pattern_class, pattern_slot,
//                                             care_mask, fixed_values,
//                                             pattern_weight, object_bits
// out       source     out_valid / out_ready  verdict, score_first, score_second
// cfg       sink       cfg_we                 cfg_wdata (match mode)
//
// Clear, load and unused commands give no result and leave in_ready high.
// A classify item walks the row of PATTERNS_PER_CLASS cells, one cell per cycle,
// so in_ready stays low while it is in the row and until its result is registered.
// Its result shows in the cycle in_ready rises; an earlier result that still
// waits in the result register delays it until that earlier result is taken.
// Reset clears all valid bits, the mode register and the result register at once.
// Items are accepted while a result waits; a finished classify holds its sums
// until the result register is free.
module ternary_pattern_vote_classifier_top #(
	parameter int NUM_FEATURES       = 64,
	parameter int PATTERNS_PER_CLASS = 64,
	parameter int WEIGHT_BITS        = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic                              pattern_class,
	input  logic [5:0]                        pattern_slot,
	input  logic [tpvc_pkg::FEAT_W-1:0]       care_mask,
	input  logic [tpvc_pkg::FEAT_W-1:0]       fixed_values,
	input  logic [tpvc_pkg::WEIGHT_IN_W-1:0]  pattern_weight,
	input  logic [tpvc_pkg::FEAT_W-1:0]       object_bits,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        verdict,
	output logic [tpvc_pkg::SCORE_W-1:0]      score_first,
	output logic [tpvc_pkg::SCORE_W-1:0]      score_second
);

	localparam int SUM_W = WEIGHT_BITS + $clog2(PATTERNS_PER_CLASS + 1);
	localparam logic [tpvc_pkg::FEAT_W-1:0] FEAT_MASK =
		{tpvc_pkg::FEAT_W{1'b1}} >> (tpvc_pkg::FEAT_W - NUM_FEATURES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic                        mode_q;
	logic                        accept;
	tpvc_pkg::load_t             ld;
	logic                        clr;
	logic [PATTERNS_PER_CLASS:0] tok_w;
	logic [tpvc_pkg::FEAT_W-1:0] obj_w [PATTERNS_PER_CLASS+1];
	logic [SUM_W-1:0]            s0_w  [PATTERNS_PER_CLASS+1];
	logic [SUM_W-1:0]            s1_w  [PATTERNS_PER_CLASS+1];
	logic [SUM_W-1:0]            fin0_q;
	logic [SUM_W-1:0]            fin1_q;
	logic                        out_valid_q;
	logic [1:0]                  verdict_q;
	logic [tpvc_pkg::SCORE_W-1:0] score0_q;
	logic [tpvc_pkg::SCORE_W-1:0] score1_q;
	logic                        out_free;
	logic [63:0]                 fin0_x;
	logic [63:0]                 fin1_x;

	// Decode the accepted item
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign clr      = accept && (cmd == tpvc_pkg::CMD_CLEAR);

	always_comb begin
		ld.en     = accept && (cmd == tpvc_pkg::CMD_LOAD);
		ld.cls    = pattern_class;
		ld.slot   = pattern_slot;
		ld.care   = care_mask & FEAT_MASK;
		ld.vals   = fixed_values & FEAT_MASK;
		ld.weight = pattern_weight;
	end

	// Inject a classify token at the head of the row
	assign tok_w[0] = accept && (cmd == tpvc_pkg::CMD_CLASSIFY);
	assign obj_w[0] = object_bits & FEAT_MASK;
	assign s0_w[0]  = '0;
	assign s1_w[0]  = '0;

	for (genvar i = 0; i < PATTERNS_PER_CLASS; i++) begin : g_cell
		tpvc_cell #(
			.IDX         (i),
			.WEIGHT_BITS (WEIGHT_BITS),
			.SUM_W       (SUM_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld      (ld),
			.clr     (clr),
			.mode    (mode_q),
			.tok_in  (tok_w[i]),
			.obj_in  (obj_w[i]),
			.s0_in   (s0_w[i]),
			.s1_in   (s1_w[i]),
			.tok_out (tok_w[i+1]),
			.obj_out (obj_w[i+1]),
			.s0_out  (s0_w[i+1]),
			.s1_out  (s1_w[i+1])
		);
	end

	// Hold the match mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Capture the final sums at the tail of the row
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && tok_w[PATTERNS_PER_CLASS]) begin
			fin0_q <= s0_w[PATTERNS_PER_CLASS];
			fin1_q <= s1_w[PATTERNS_PER_CLASS];
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign fin0_x   = 64'(fin0_q);
	assign fin1_x   = 64'(fin1_q);

	// Sequence the classify and fill the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			verdict_q   <= tpvc_pkg::VERDICT_TIE;
			score0_q    <= '0;
			score1_q    <= '0;
		end else begin
			// Drop a taken result unless a new one replaces it
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tok_w[0]) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tok_w[PATTERNS_PER_CLASS]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (fin0_q > fin1_q) begin
							verdict_q <= tpvc_pkg::VERDICT_FIRST;
						end else if (fin0_q < fin1_q) begin
							verdict_q <= tpvc_pkg::VERDICT_SECOND;
						end else begin
							verdict_q <= tpvc_pkg::VERDICT_TIE;
						end
						score0_q <= (fin0_x > 64'(tpvc_pkg::SCORE_MAX)) ?
							tpvc_pkg::SCORE_MAX : fin0_x[tpvc_pkg::SCORE_W-1:0];
						score1_q <= (fin1_x > 64'(tpvc_pkg::SCORE_MAX)) ?
							tpvc_pkg::SCORE_MAX : fin1_x[tpvc_pkg::SCORE_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign score_first  = score0_q;
	assign score_second = score1_q;

	// At most one classify token travels the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_w) <= 1)
		else $error("more than one classify token in the cell row");

	// A token leaving the row is only seen while a classify runs
	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok_w[PATTERNS_PER_CLASS] |-> (state_q == ST_RUN))
		else $error("token left the row outside a classify");

	// No item is taken in the cycle after a classify is accepted
	a_busy_after_classify: assert property (@(posedge clk) disable iff (!arst_n)
		tok_w[0] |=> !in_ready)
		else $error("item accepted while a classify is in the row");

	// A delivered verdict is always a defined code
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict != 2'd3))
		else $error("undefined verdict code on the output");

endmodule
